// File: hdl/mtep_pkg.sv
// Package for the MIDI track event parser: parse phases, result kinds,
// status byte constants and the result word type.
// No dependencies.
package mtep_pkg;

  // Parse phase of the track byte stream
  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_METATYPE = 4'd4,
    PH_LEN      = 4'd5,
    PH_BODY     = 4'd6,
    PH_HALT     = 4'd7
  } phase_t;

  // Result kinds
  localparam logic [2:0] KIND_DELTA = 3'd0;
  localparam logic [2:0] KIND_OFF   = 3'd1;
  localparam logic [2:0] KIND_ON    = 3'd2;
  localparam logic [2:0] KIND_TEMPO = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // Error codes
  localparam logic ERR_TRUNCATED = 1'b0;
  localparam logic ERR_NO_STATUS = 1'b1;

  // Status and meta constants
  localparam logic [3:0] HI_SYSTEM   = 4'hf;
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_PROGRAM  = 4'hc;
  localparam logic [3:0] HI_PRESSURE = 4'hd;
  localparam logic [2:0] TOP3_NOTE   = 3'b100;
  localparam logic [7:0] META_TEMPO  = 8'h51;

  // Result queue geometry
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  // One result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [7:0]  key;
    logic [7:0]  velocity;
    logic [31:0] value;
    logic        error_code;
    logic        last;
  } res_t;

endpackage

// File: hdl/midi_track_event_parser.sv
// Top level of the MIDI track event parser: byte-wise parse logic and
// a small result queue. Depends on mtep_pkg.
//
// One track byte is accepted per clock cycle while in_ready is high. Each
// byte is parsed in the cycle it is accepted, and the zero, one or two
// result words it causes are written to a four-entry result queue that
// drains one word per cycle while out_ready is high. in_ready is high
// while the queue has at least two free entries; a byte that causes two
// results (a delta time completing on the last byte of a track, which then
// also reports the unfinished event) needs two output words, so such bytes
// lower the sustained input rate below one byte per cycle when the output
// is drained at full rate.
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  input  logic        in_track_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_key,
  output logic [7:0]  out_velocity,
  output logic [31:0] out_value,
  output logic        out_error_code,
  output logic        out_last
);
  import mtep_pkg::*;

  // Parser state
  logic [7:0]  rs_r, rs_nxt, rs_c;
  phase_t      ph_r, ph_nxt, ph_c;
  logic [27:0] acc_r, acc_nxt, acc_c;
  logic [2:0]  cnt_r, cnt_nxt, cnt_c;
  logic [7:0]  mk_r, mk_nxt;
  logic [27:0] rem_r, rem_nxt;
  logic [31:0] tempo_r, tempo_nxt;
  logic [7:0]  fd_r, fd_nxt;

  // State as seen after a track start clear
  logic [7:0]  rs_e, mk_e, fd_e;
  phase_t      ph_e;
  logic [27:0] acc_e, rem_e, rem_dec;
  logic [2:0]  cnt_e, cnt_t;
  logic [31:0] tempo_e, tempo_sh;
  logic [27:0] acc_t;
  logic        vl_done;
  logic        take;
  logic [7:0]  b;
  logic        mid;

  // Result queue
  res_t                 q_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_r, rd_r;
  logic [RES_CNT_W-1:0] cnt_q_r;
  res_t                 r0, r1, e0;
  logic                 r0_v, r1_v;
  logic                 pop;
  logic [1:0]           n_push;

  assign take = in_valid && in_ready;
  assign b    = in_data_byte;

  // Clear on track start before the byte is handled
  assign rs_e    = in_track_start ? 8'd0 : rs_r;
  assign ph_e    = in_track_start ? PH_DELTA : ph_r;
  assign acc_e   = in_track_start ? 28'd0 : acc_r;
  assign cnt_e   = in_track_start ? 3'd0 : cnt_r;
  assign mk_e    = in_track_start ? 8'd0 : mk_r;
  assign rem_e   = in_track_start ? 28'd0 : rem_r;
  assign tempo_e = in_track_start ? 32'd0 : tempo_r;
  assign fd_e    = in_track_start ? 8'd0 : fd_r;

  // Variable-length quantity step, ending after four bytes at most
  assign acc_t    = {acc_e[20:0], b[6:0]};
  assign cnt_t    = cnt_e + 3'd1;
  assign vl_done  = !b[7] || (cnt_t >= 3'd4);
  assign rem_dec  = rem_e - 28'd1;
  assign tempo_sh = {tempo_e[23:0], b};

  // Next state of the parser, before the track end override
  always_comb begin
    rs_c      = rs_e;
    ph_c      = ph_e;
    acc_c     = acc_e;
    cnt_c     = cnt_e;
    mk_nxt    = mk_e;
    rem_nxt   = rem_e;
    tempo_nxt = tempo_e;
    fd_nxt    = fd_e;
    unique case (ph_e)
      PH_DELTA: begin
        if (vl_done) begin
          acc_c = 28'd0;
          cnt_c = 3'd0;
          ph_c  = PH_STATUS;
        end else begin
          acc_c = acc_t;
          cnt_c = cnt_t;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          rs_c = b;
          if (b[7:4] == HI_SYSTEM) begin
            mk_nxt = 8'd0;
            if (b[3]) begin
              ph_c = PH_METATYPE;
            end else begin
              acc_c = 28'd0;
              cnt_c = 3'd0;
              ph_c  = PH_LEN;
            end
          end else begin
            ph_c = PH_DATA1;
          end
        end else if (!rs_e[7]) begin
          ph_c = PH_HALT;
        end else if (rs_e[7:4] == HI_SYSTEM) begin
          acc_c = 28'd0;
          cnt_c = 3'd0;
          if (rs_e[3]) begin
            mk_nxt = b;
            ph_c   = PH_LEN;
          end else begin
            // data byte is the whole length field of a sysex
            mk_nxt    = 8'd0;
            rem_nxt   = {21'd0, b[6:0]};
            tempo_nxt = 32'd0;
            ph_c      = (b[6:0] == 7'd0) ? PH_DELTA : PH_BODY;
          end
        end else begin
          fd_nxt = b;
          ph_c   = (rs_e[7:4] == HI_PROGRAM || rs_e[7:4] == HI_PRESSURE) ?
                   PH_DELTA : PH_DATA2;
        end
      end
      PH_DATA1: begin
        fd_nxt = b;
        ph_c   = (rs_e[7:4] == HI_PROGRAM || rs_e[7:4] == HI_PRESSURE) ?
                 PH_DELTA : PH_DATA2;
      end
      PH_DATA2: begin
        ph_c = PH_DELTA;
      end
      PH_METATYPE: begin
        mk_nxt = b;
        acc_c  = 28'd0;
        cnt_c  = 3'd0;
        ph_c   = PH_LEN;
      end
      PH_LEN: begin
        if (vl_done) begin
          rem_nxt   = acc_t;
          tempo_nxt = 32'd0;
          acc_c     = 28'd0;
          cnt_c     = 3'd0;
          ph_c      = (acc_t == 28'd0) ? PH_DELTA : PH_BODY;
        end else begin
          acc_c = acc_t;
          cnt_c = cnt_t;
        end
      end
      PH_BODY: begin
        rem_nxt = rem_dec;
        if (mk_e == META_TEMPO) begin
          tempo_nxt = tempo_sh;
        end
        if (rem_dec == 28'd0) begin
          ph_c = PH_DELTA;
        end
      end
      default: begin
      end
    endcase
  end

  // Track end: flag an unfinished event and return to delta time
  assign mid = ((ph_c != PH_DELTA) && (ph_c != PH_HALT)) ||
               ((ph_c == PH_DELTA) && (cnt_c != 3'd0));
  assign rs_nxt  = rs_c;
  assign ph_nxt  = in_track_end ? PH_DELTA : ph_c;
  assign acc_nxt = in_track_end ? 28'd0 : acc_c;
  assign cnt_nxt = in_track_end ? 3'd0 : cnt_c;

  // Results of the byte
  always_comb begin
    r0   = '0;
    r0_v = 1'b0;
    unique case (ph_e)
      PH_DELTA: begin
        if (vl_done) begin
          r0_v       = 1'b1;
          r0.kind    = KIND_DELTA;
          r0.value   = {4'd0, acc_t};
        end
      end
      PH_STATUS: begin
        if (!b[7] && !rs_e[7]) begin
          r0_v          = 1'b1;
          r0.kind       = KIND_ERR;
          r0.error_code = ERR_NO_STATUS;
        end
      end
      PH_DATA2: begin
        if (rs_e[7:5] == TOP3_NOTE) begin
          r0_v        = 1'b1;
          r0.kind     = (rs_e[7:4] == HI_NOTE_OFF || b == 8'd0) ? KIND_OFF : KIND_ON;
          r0.channel  = rs_e[3:0];
          r0.key      = fd_e;
          r0.velocity = b;
        end
      end
      PH_LEN: begin
        if (vl_done && acc_t == 28'd0 && mk_e == META_TEMPO) begin
          r0_v    = 1'b1;
          r0.kind = KIND_TEMPO;
        end
      end
      PH_BODY: begin
        if (rem_dec == 28'd0 && mk_e == META_TEMPO) begin
          r0_v     = 1'b1;
          r0.kind  = KIND_TEMPO;
          r0.value = tempo_sh;
        end
      end
      default: begin
      end
    endcase
    r1            = '0;
    r1_v          = in_track_end && mid;
    r1.kind       = KIND_ERR;
    r1.error_code = ERR_TRUNCATED;
    r1.last       = 1'b1;
    if (!r1_v) begin
      r0.last = 1'b1;
    end
  end

  // Word for the first queue slot of this byte
  assign e0     = r0_v ? r0 : r1;
  assign n_push = take ? ({1'b0, r0_v} + {1'b0, r1_v}) : 2'd0;
  assign pop    = out_valid && out_ready;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r    <= 8'd0;
      ph_r    <= PH_DELTA;
      acc_r   <= 28'd0;
      cnt_r   <= 3'd0;
      mk_r    <= 8'd0;
      rem_r   <= 28'd0;
      tempo_r <= 32'd0;
      fd_r    <= 8'd0;
    end else if (take) begin
      rs_r    <= rs_nxt;
      ph_r    <= ph_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      mk_r    <= mk_nxt;
      rem_r   <= rem_nxt;
      tempo_r <= tempo_nxt;
      fd_r    <= fd_nxt;
    end
  end

  // Advance result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      cnt_q_r <= '0;
    end else begin
      wr_r    <= wr_r + RES_PTR_W'(n_push);
      rd_r    <= rd_r + RES_PTR_W'(pop);
      cnt_q_r <= cnt_q_r + RES_CNT_W'(n_push) - RES_CNT_W'(pop);
    end
  end

  // Write result words
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_r] <= e0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_r + RES_PTR_W'(1)] <= r1;
    end
  end

  assign in_ready       = cnt_q_r <= RES_CNT_W'(RES_DEPTH - 2);
  assign out_valid      = cnt_q_r != '0;
  assign out_kind       = q_r[rd_r].kind;
  assign out_channel    = q_r[rd_r].channel;
  assign out_key        = q_r[rd_r].key;
  assign out_velocity   = q_r[rd_r].velocity;
  assign out_value      = q_r[rd_r].value;
  assign out_error_code = q_r[rd_r].error_code;
  assign out_last       = q_r[rd_r].last;

endmodule

// File: hdl/mtep_checker.sv
// Port-level checks for the MIDI track event parser, bound to the top level.
// Depends on mtep_pkg and midi_track_event_parser.
module mtep_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_velocity,
  input logic [31:0] out_value,
  input logic        out_last
);
  import mtep_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_value) && $stable(out_last))
    else $error("stalled result word changed");

  // An error is always the final word of its byte
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERR |-> out_last)
    else $error("error word not marked last");

  // Delta times carry at most 28 bits
  a_delta_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DELTA |-> out_value[31:28] == 4'd0)
    else $error("delta time wider than 28 bits");

  // Zero velocity never reports as note-on
  a_note_on_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ON |-> out_velocity != 8'd0)
    else $error("note-on with zero velocity");

endmodule

bind midi_track_event_parser mtep_port_checks u_mtep_port_checks (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_kind     (out_kind),
  .out_velocity (out_velocity),
  .out_value    (out_value),
  .out_last     (out_last)
);

// File: tb/mtep_checker.sv
// Checker for the MIDI track event parser: watches both channels, predicts
// the result words of every accepted track byte and compares them in order.
// Depends on mtep_pkg.
module mtep_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  input  logic        in_track_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [3:0]  out_channel,
  input  logic [7:0]  out_key,
  input  logic [7:0]  out_velocity,
  input  logic [31:0] out_value,
  input  logic        out_error_code,
  input  logic        out_last,
  output int          fail_count,
  output int          words_waiting,
  output int          words_checked
);
  import mtep_pkg::*;

  // Parser state as predicted
  logic [7:0]  held_status;
  phase_t      phase;
  logic [27:0] vlq_acc;
  logic [2:0]  vlq_count;
  logic [7:0]  meta_code;
  logic [27:0] body_left;
  logic [31:0] tempo_shift;
  logic [7:0]  note_key;

  res_t due_events[$];
  res_t byte_events[$];
  int   mismatches;
  int   checked;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 20)
      $display("[%0t] word %0d %s: got 0x%0h, expected 0x%0h",
               $time, checked, what, got, want);
    mismatches++;
  endtask

  task automatic add_event(input logic [2:0] kind, input logic [3:0] ch,
                           input logic [7:0] key, input logic [7:0] vel,
                           input logic [31:0] value, input logic err);
    res_t r;
    r = '0;
    r.kind = kind;
    r.channel = ch;
    r.key = key;
    r.velocity = vel;
    r.value = value;
    r.error_code = err;
    byte_events.push_back(r);
  endtask

  // Shift one byte into the variable-length quantity; true once it is complete
  function automatic logic vlq_take(input logic [7:0] b);
    vlq_acc = {vlq_acc[20:0], b[6:0]};
    vlq_count = vlq_count + 3'd1;
    return !b[7] || vlq_count >= 3'd4;
  endfunction

  task automatic vlq_clear();
    vlq_acc = '0;
    vlq_count = '0;
  endtask

  task automatic start_length();
    vlq_clear();
    phase = PH_LEN;
  endtask

  // Meta statuses carry a type byte first, sysex goes straight to its length
  task automatic begin_system();
    meta_code = '0;
    if (held_status[3]) phase = PH_METATYPE;
    else start_length();
  endtask

  task automatic take_first_data(input logic [7:0] b);
    note_key = b;
    if (held_status[7:4] == HI_PROGRAM || held_status[7:4] == HI_PRESSURE)
      phase = PH_DELTA;
    else
      phase = PH_DATA2;
  endtask

  // Length known: skip the body, or close the event at once when it is empty
  task automatic finish_length();
    body_left = vlq_acc;
    tempo_shift = '0;
    vlq_clear();
    if (body_left == '0) begin
      if (meta_code == META_TEMPO) add_event(KIND_TEMPO, '0, '0, '0, '0, 1'b0);
      phase = PH_DELTA;
    end else begin
      phase = PH_BODY;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic start,
                            input logic stop);
    logic off;
    logic mid;
    res_t r;
    byte_events.delete();
    if (start) begin
      held_status = '0;
      phase = PH_DELTA;
      vlq_clear();
      meta_code = '0;
      body_left = '0;
      tempo_shift = '0;
      note_key = '0;
    end
    case (phase)
      PH_DELTA: begin
        if (vlq_take(b)) begin
          add_event(KIND_DELTA, '0, '0, '0, {4'd0, vlq_acc}, 1'b0);
          vlq_clear();
          phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          held_status = b;
          if (b[7:4] == HI_SYSTEM) begin_system();
          else phase = PH_DATA1;
        end else if (!held_status[7]) begin
          add_event(KIND_ERR, '0, '0, '0, '0, ERR_NO_STATUS);
          phase = PH_HALT;
        end else if (held_status[7:4] == HI_SYSTEM) begin
          // running status on a system event: byte is the type or the length
          begin_system();
          if (phase == PH_METATYPE) begin
            meta_code = b;
            start_length();
          end else if (vlq_take(b)) begin
            finish_length();
          end
        end else begin
          take_first_data(b);
        end
      end
      PH_DATA1: take_first_data(b);
      PH_DATA2: begin
        if (held_status[7:5] == TOP3_NOTE) begin
          off = (held_status[7:4] == HI_NOTE_OFF) || (b == 8'd0);
          add_event(off ? KIND_OFF : KIND_ON, held_status[3:0], note_key, b, '0, 1'b0);
        end
        phase = PH_DELTA;
      end
      PH_METATYPE: begin
        meta_code = b;
        start_length();
      end
      PH_LEN: begin
        if (vlq_take(b)) finish_length();
      end
      PH_BODY: begin
        body_left = body_left - 28'd1;
        if (meta_code == META_TEMPO) tempo_shift = {tempo_shift[23:0], b};
        if (body_left == '0) begin
          if (meta_code == META_TEMPO)
            add_event(KIND_TEMPO, '0, '0, '0, tempo_shift, 1'b0);
          phase = PH_DELTA;
        end
      end
      default: ;
    endcase
    // Track end: flag an unfinished event unless the track already failed
    if (stop) begin
      mid = (phase != PH_DELTA && phase != PH_HALT) ||
            (phase == PH_DELTA && vlq_count != 3'd0);
      if (mid) add_event(KIND_ERR, '0, '0, '0, '0, ERR_TRUNCATED);
      phase = PH_DELTA;
      vlq_clear();
    end
    if (byte_events.size() > 0) begin
      r = byte_events.pop_back();
      r.last = 1'b1;
      byte_events.push_back(r);
    end
    foreach (byte_events[i]) due_events.push_back(byte_events[i]);
  endtask

  // Compare each output word first, then predict from the accepted byte
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      held_status = '0;
      phase = PH_DELTA;
      vlq_clear();
      meta_code = '0;
      body_left = '0;
      tempo_shift = '0;
      note_key = '0;
      due_events.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          report_mismatch("arrived with nothing due, kind", out_kind, '0);
        end else begin
          want = due_events.pop_front();
          if (out_kind != want.kind) report_mismatch("kind", out_kind, want.kind);
          if (out_channel != want.channel)
            report_mismatch("channel", out_channel, want.channel);
          if (out_key != want.key) report_mismatch("key", out_key, want.key);
          if (out_velocity != want.velocity)
            report_mismatch("velocity", out_velocity, want.velocity);
          if (out_value != want.value) report_mismatch("value", out_value, want.value);
          if (out_error_code != want.error_code)
            report_mismatch("error_code", out_error_code, want.error_code);
          if (out_last != want.last) report_mismatch("last", out_last, want.last);
        end
        checked++;
      end
      if (in_valid && in_ready) parse_byte(in_data_byte, in_track_start, in_track_end);
    end
    fail_count <= mismatches;
    words_waiting <= due_events.size();
    words_checked <= checked;
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the MIDI track event parser: clock, reset, track byte
// stimulus, output back-pressure and verdict. Depends on mtep_pkg,
// midi_track_event_parser and mtep_checker.
module tb_top;
  import mtep_pkg::*;

  localparam int          STALL_LIMIT  = 1000;
  localparam int          BYTE_TARGET  = 1800;
  localparam logic [3:0]  HI_NOTE_ON   = 4'h9;
  localparam logic [3:0]  HI_POLY      = 4'ha;
  localparam logic [3:0]  HI_CONTROL   = 4'hb;
  localparam logic [3:0]  HI_PITCH     = 4'he;
  localparam logic [7:0]  SYSEX_FIRST  = 8'hf0;
  localparam logic [7:0]  SYSEX_LAST   = 8'hf7;
  localparam logic [7:0]  META_FIRST   = 8'hf8;
  localparam logic [7:0]  META_STATUS  = 8'hff;
  localparam logic [7:0]  META_END     = 8'h2f;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_track_start = 1'b0;
  logic        in_track_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [3:0]  out_channel;
  logic [7:0]  out_key;
  logic [7:0]  out_velocity;
  logic [31:0] out_value;
  logic        out_error_code;
  logic        out_last;

  int          fail_count;
  int          words_waiting;
  int          words_checked;
  int          bytes_sent = 0;
  int          tracks_sent = 0;
  int          quiet_cycles = 0;
  logic        calm = 1'b0;
  logic [7:0]  track_bytes[$];
  logic [7:0]  gen_status;

  midi_track_event_parser uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_track_start (in_track_start),
    .in_track_end   (in_track_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_channel    (out_channel),
    .out_key        (out_key),
    .out_velocity   (out_velocity),
    .out_value      (out_value),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  mtep_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_track_start (in_track_start),
    .in_track_end   (in_track_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_channel    (out_channel),
    .out_key        (out_key),
    .out_velocity   (out_velocity),
    .out_value      (out_value),
    .out_error_code (out_error_code),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .words_waiting  (words_waiting),
    .words_checked  (words_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side now and then, never during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 6);
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("midi_track_event_parser: mismatch");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until taken, idling first now and then
  task automatic send_byte(input logic [7:0] b, input logic first, input logic final_b);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_track_start <= first;
    in_track_end <= final_b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    calm <= (bytes_sent >= 700 && bytes_sent < 1000);
  endtask

  task automatic send_track(input int count);
    for (int i = 0; i < count; i++)
      send_byte(track_bytes[i], i == 0, i == count - 1);
    tracks_sent++;
  endtask

  task automatic push_varlen(input logic [27:0] v);
    if (v >= 28'h020_0000) track_bytes.push_back({1'b1, v[27:21]});
    if (v >= 28'h000_4000) track_bytes.push_back({1'b1, v[20:14]});
    if (v >= 28'h000_0080) track_bytes.push_back({1'b1, v[13:7]});
    track_bytes.push_back({1'b0, v[6:0]});
  endtask

  // Mostly short delta times; now and then four bytes that all carry the continuation bit
  task automatic push_delta();
    int r;
    r = $urandom_range(99);
    if (r < 50) push_varlen('0);
    else if (r < 80) push_varlen(28'($urandom_range(127, 1)));
    else if (r < 92) push_varlen(28'($urandom_range(16383, 128)));
    else if (r < 97) push_varlen(28'($urandom));
    else repeat (4) track_bytes.push_back(8'($urandom_range(255)) | 8'h80);
  endtask

  task automatic push_body(input int len);
    repeat (len) track_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Build a track of one to six random events in track_bytes
  task automatic build_track();
    int r;
    int len;
    logic [7:0] st;
    logic [3:0] hi;
    track_bytes.delete();
    gen_status = '0;
    repeat ($urandom_range(6, 1)) begin
      push_delta();
      r = $urandom_range(99);
      len = ($urandom_range(99) < 4) ? $urandom_range(300, 128) : $urandom_range(8, 0);
      if (r >= 80 && gen_status[7:4] == HI_SYSTEM) begin
        // running status on a system event
        if (gen_status[3]) begin
          track_bytes.push_back(($urandom_range(1) == 0) ? META_TEMPO : 8'($urandom_range(127)));
          push_varlen(28'(len));
        end else begin
          len = $urandom_range(12, 0);
          track_bytes.push_back(8'(len));
        end
        push_body(len);
      end else if (r >= 60) begin
        // sysex or meta with an explicit status
        if ($urandom_range(1) == 0) begin
          st = ($urandom_range(3) == 0) ? 8'($urandom_range(META_STATUS, META_FIRST))
                                        : META_STATUS;
          track_bytes.push_back(st);
          track_bytes.push_back(($urandom_range(1) == 0) ? META_TEMPO
                                                         : 8'($urandom_range(255)));
        end else begin
          st = 8'($urandom_range(SYSEX_LAST, SYSEX_FIRST));
          track_bytes.push_back(st);
        end
        gen_status = st;
        push_varlen(28'(len));
        push_body(len);
      end else begin
        // channel message, reusing the held status where possible
        if (gen_status[7] && gen_status[7:4] != HI_SYSTEM && $urandom_range(2) != 0) begin
          st = gen_status;
          track_bytes.push_back(8'($urandom_range(127)));
        end else begin
          case ($urandom_range(6))
            0:       hi = HI_NOTE_OFF;
            1, 2:    hi = HI_NOTE_ON;
            3:       hi = HI_POLY;
            4:       hi = HI_CONTROL;
            5:       hi = ($urandom_range(1) == 0) ? HI_PROGRAM : HI_PRESSURE;
            default: hi = HI_PITCH;
          endcase
          st = {hi, 4'($urandom_range(15))};
          gen_status = st;
          track_bytes.push_back(st);
          track_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(127)));
        end
        if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE)
          track_bytes.push_back(($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255)));
      end
    end
    // usual end-of-track meta event
    if ($urandom_range(3) != 0) begin
      track_bytes.push_back(8'h00);
      track_bytes.push_back(META_STATUS);
      track_bytes.push_back(META_END);
      track_bytes.push_back(8'h00);
    end
  endtask

  initial begin
    int r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: note on at the extremes, overlong delta with note off on
    // channel 15, empty tempo, running status on a meta event
    send_byte(8'h00, 1, 0); send_byte(8'h90, 0, 0); send_byte(8'h00, 0, 0);
    send_byte(8'h7f, 0, 0);
    send_byte(8'hff, 0, 0); send_byte(8'hff, 0, 0); send_byte(8'hff, 0, 0);
    send_byte(8'hff, 0, 0); send_byte(8'h8f, 0, 0); send_byte(8'hff, 0, 0);
    send_byte(8'hff, 0, 0);
    send_byte(8'h00, 0, 0); send_byte(META_STATUS, 0, 0); send_byte(META_TEMPO, 0, 0);
    send_byte(8'h00, 0, 0);
    send_byte(8'h00, 0, 0); send_byte(META_END, 0, 0); send_byte(8'h00, 0, 0);
    // Data byte with no status, then a byte that is dropped
    send_byte(8'h00, 1, 0); send_byte(8'h40, 0, 0); send_byte(8'h12, 0, 1);
    // Note on, then a delta time on the last byte of the track
    send_byte(8'h00, 1, 0); send_byte(8'h90, 0, 0); send_byte(8'h3c, 0, 0);
    send_byte(8'h40, 0, 0); send_byte(8'h05, 0, 1);
    tracks_sent = 3;

    // Random: mostly whole tracks, some cut short, some noise
    while (bytes_sent < BYTE_TARGET) begin
      r = $urandom_range(99);
      if (r < 78) begin
        build_track();
        send_track(track_bytes.size());
      end else if (r < 86) begin
        build_track();
        send_track(track_bytes.size() > 1 ? $urandom_range(track_bytes.size() - 1, 1) : 1);
      end else if (r < 90) begin
        track_bytes.delete();
        push_delta();
        track_bytes.push_back(8'($urandom_range(127)));
        push_body($urandom_range(6, 0));
        send_track(track_bytes.size());
      end else begin
        repeat ($urandom_range(20, 4))
          send_byte(8'($urandom_range(255)), $urandom_range(9) == 0, $urandom_range(9) == 0);
      end
      // Hold the input until the result queue has drained
      if (tracks_sent % 20 == 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_waiting != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d track bytes in about %0d tracks with noise and cut tracks",
             bytes_sent, tracks_sent);
    $display("compared %0d result words field by field", words_checked);
    if (fail_count == 0) begin
      $display("midi_track_event_parser: match");
    end else begin
      $display("midi_track_event_parser: mismatch");
    end
    $finish;
  end

endmodule
